// ===== sv/cbrd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbrd_pkg
// Shared types and constants of the counter-based random draw block.
// ----------------------------------------------------------------------------
package cbrd_pkg;

   localparam int WORD_W   = 64;
   localparam int HALF_W   = 32;
   localparam int BOUND_W  = 32;
   localparam int SPAN_W   = 33;
   localparam int FRAC_W   = 53;
   localparam int PROB_W   = 54;

   localparam logic [WORD_W-1:0] GOLDEN_STEP = 64'h9E37_79B9_7F4A_7C15;
   localparam logic [WORD_W-1:0] MIX_MUL_A   = 64'hBF58_476D_1CE4_E5B9;
   localparam logic [WORD_W-1:0] MIX_MUL_B   = 64'h94D0_49BB_1331_11EB;

   localparam int SHIFT_A = 30;
   localparam int SHIFT_B = 27;
   localparam int SHIFT_C = 31;

   localparam logic [PROB_W-1:0] PROB_ONE = PROB_W'(1) << FRAC_W;

   typedef enum logic [1:0] {
      CMD_RAW  = 2'd0,
      CMD_INT  = 2'd1,
      CMD_FRAC = 2'd2,
      CMD_BOOL = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCALE,
      ST_MIX_A,
      ST_MIX_B,
      ST_REDUCE,
      ST_RESPOND
   } state_type;

endpackage

// ===== sv/cbrd_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbrd_req_if
// Request channel: draw command, integer range bounds and probability.
// ----------------------------------------------------------------------------
interface cbrd_req_if;
   logic               valid;
   logic               ready;
   logic        [1:0]  command;
   logic signed [31:0] range_low;
   logic signed [31:0] range_high;
   logic        [53:0] probability;

   modport source (output valid, command, range_low, range_high, probability,
                   input ready);
   modport sink   (input valid, command, range_low, range_high, probability,
                   output ready);
endinterface

// ===== sv/cbrd_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbrd_rsp_if
// Response channel: raw word, derived results and the draw number.
// ----------------------------------------------------------------------------
interface cbrd_rsp_if;
   logic               valid;
   logic               ready;
   logic        [63:0] raw_value;
   logic signed [31:0] int_value;
   logic        [52:0] unit_fraction;
   logic               bool_value;
   logic        [63:0] draw_number;
   logic               range_error;

   modport source (output valid, raw_value, int_value, unit_fraction, bool_value,
                   draw_number, range_error, input ready);
   modport sink   (input valid, raw_value, int_value, unit_fraction, bool_value,
                   draw_number, range_error, output ready);
endinterface

// ===== sv/counter_based_random_draw.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// counter_based_random_draw
// Counter-indexed splitmix64 draw unit with range, fraction and boolean results.
// ----------------------------------------------------------------------------
// Each request beat on req_chan consumes one draw: the draw counter steps, the
// scaled counter plus the seed is mixed, and one response beat follows on
// rsp_chan. The seed is written through csr_wr_en and csr_wr_data; the user
// must write it only while the block is idle, as the block does not enforce
// this. One shared 32 by 32 multiplier forms each of the three 64-bit products
// in turn; a bit-serial remainder unit then reduces a valid integer range draw.
// The block works on one item at a time: req_chan.ready is low from the
// request beat until the response beat is taken, and the response holds while
// the receiver stalls. Reset clears the draw counter and the seed and leaves
// the block idle.
// ----------------------------------------------------------------------------
module counter_based_random_draw
   import cbrd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   cbrd_req_if.sink          req_chan,
   cbrd_rsp_if.source        rsp_chan,
   input  logic              csr_wr_en,
   input  logic [WORD_W-1:0] csr_wr_data
);

   state_type          state_ff, state_in;
   logic [WORD_W-1:0]  seed_ff, counter_ff, raw_ff;
   cmd_type            cmd_ff;
   logic [BOUND_W-1:0] low_ff, ival_ff;
   logic [SPAN_W-1:0]  span_ff;
   logic [PROB_W-1:0]  prob_ff;
   logic               err_ff, bool_ff;

   logic               mul_start, mul_done, mod_start, mod_done;
   logic [WORD_W-1:0]  mul_a, mul_b, mul_p, mixed, raw_in;
   logic [BOUND_W-1:0] mod_rem;
   logic               accept, load_raw, load_int;
   logic [SPAN_W-1:0]  span_in;
   logic [PROB_W-1:0]  prob_in;
   logic               err_in;

   cbrd_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .done    (mul_done),
      .product (mul_p)
   );

   cbrd_mod u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (raw_in),
      .divisor   (span_ff),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   assign accept  = req_chan.valid && req_chan.ready;
   assign mixed   = seed_ff + mul_p;
   assign raw_in  = mul_p ^ (mul_p >> SHIFT_C);
   assign span_in = SPAN_W'({req_chan.range_high[BOUND_W-1], req_chan.range_high}
                            - {req_chan.range_low[BOUND_W-1], req_chan.range_low}
                            + SPAN_W'(1));
   assign err_in  = (cmd_type'(req_chan.command) == CMD_INT)
                    && (req_chan.range_low > req_chan.range_high);
   assign prob_in = (req_chan.probability > PROB_ONE) ? PROB_ONE : req_chan.probability;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:    if (req_chan.valid) state_in = ST_SCALE;
         ST_SCALE:   if (mul_done) state_in = ST_MIX_A;
         ST_MIX_A:   if (mul_done) state_in = ST_MIX_B;
         ST_MIX_B: begin
            if (mul_done) begin
               if (cmd_ff == CMD_INT && !err_ff) begin
                  state_in = ST_REDUCE;
               end else begin
                  state_in = ST_RESPOND;
               end
            end
         end
         ST_REDUCE:  if (mod_done) state_in = ST_RESPOND;
         ST_RESPOND: if (rsp_chan.ready) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      mul_start = 1'b0;
      mod_start = 1'b0;
      mul_a     = counter_ff + WORD_W'(1);
      mul_b     = GOLDEN_STEP;
      load_raw  = 1'b0;
      load_int  = 1'b0;
      unique case (state_ff)
         ST_IDLE:  mul_start = req_chan.valid;
         ST_SCALE: begin
            mul_start = mul_done;
            mul_a     = mixed ^ (mixed >> SHIFT_A);
            mul_b     = MIX_MUL_A;
         end
         ST_MIX_A: begin
            mul_start = mul_done;
            mul_a     = mul_p ^ (mul_p >> SHIFT_B);
            mul_b     = MIX_MUL_B;
         end
         ST_MIX_B: begin
            load_raw  = mul_done;
            mod_start = mul_done && (cmd_ff == CMD_INT) && !err_ff;
         end
         ST_REDUCE:  load_int = mod_done;
         ST_RESPOND: ;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         seed_ff    <= '0;
         counter_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            seed_ff <= csr_wr_data;
         end
         if (accept) begin
            counter_ff <= counter_ff + WORD_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff  <= cmd_type'(req_chan.command);
         low_ff  <= req_chan.range_low;
         span_ff <= span_in;
         err_ff  <= err_in;
         prob_ff <= prob_in;
      end
      if (load_raw) begin
         raw_ff  <= raw_in;
         ival_ff <= '0;
         bool_ff <= (cmd_ff == CMD_BOOL)
                    && (PROB_W'(raw_in[WORD_W-1:WORD_W-FRAC_W]) < prob_ff);
      end
      if (load_int) begin
         ival_ff <= low_ff + mod_rem;
      end
   end

   assign req_chan.ready         = (state_ff == ST_IDLE);
   assign rsp_chan.valid         = (state_ff == ST_RESPOND);
   assign rsp_chan.raw_value     = raw_ff;
   assign rsp_chan.int_value     = ival_ff;
   assign rsp_chan.unit_fraction = raw_ff[WORD_W-1:WORD_W-FRAC_W];
   assign rsp_chan.bool_value    = bool_ff;
   assign rsp_chan.draw_number   = counter_ff;
   assign rsp_chan.range_error   = err_ff;

endmodule

// ===== sv/cbrd_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbrd_mul
// Low 64 bits of a 64 by 64 product from three 32 by 32 partial products.
// ----------------------------------------------------------------------------
module cbrd_mul
   import cbrd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [WORD_W-1:0] op_a,
   input  logic [WORD_W-1:0] op_b,
   output logic              done,
   output logic [WORD_W-1:0] product
);

   logic [WORD_W-1:0] a_ff, b_ff, pp_ff, acc_ff;
   logic [1:0]        step_ff;
   logic              busy_ff, done_ff;
   logic [HALF_W-1:0] sel_a, sel_b;

   always_comb begin
      sel_a = a_ff[HALF_W-1:0];
      sel_b = b_ff[HALF_W-1:0];
      case (step_ff)
         2'd1: sel_a = a_ff[WORD_W-1:HALF_W];
         2'd2: sel_b = b_ff[WORD_W-1:HALF_W];
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= 2'd0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= busy_ff && (step_ff == 2'd3);
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= 2'd0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 2'd1;
            if (step_ff == 2'd3) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         a_ff <= op_a;
         b_ff <= op_b;
      end
      if (busy_ff) begin
         pp_ff <= WORD_W'(sel_a) * WORD_W'(sel_b);
         case (step_ff)
            2'd0: acc_ff <= '0;
            2'd1: acc_ff <= pp_ff;
            default: acc_ff <= acc_ff + {pp_ff[HALF_W-1:0], {HALF_W{1'b0}}};
         endcase
      end
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

// ===== sv/cbrd_mod.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbrd_mod
// Bit-serial restoring remainder of a 64-bit word by a 33-bit span.
// ----------------------------------------------------------------------------
module cbrd_mod
   import cbrd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [WORD_W-1:0]  dividend,
   input  logic [SPAN_W-1:0]  divisor,
   output logic               done,
   output logic [BOUND_W-1:0] remainder
);

   localparam int CNT_W = $clog2(WORD_W);

   logic [WORD_W-1:0]  dvd_ff;
   logic [SPAN_W-1:0]  div_ff;
   logic [BOUND_W-1:0] rem_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic               busy_ff, done_ff;
   logic [SPAN_W-1:0]  trial;
   logic [SPAN_W-1:0]  diff;

   assign trial = {rem_ff, dvd_ff[WORD_W-1]};
   assign diff  = trial - div_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == CNT_W'(WORD_W - 1));
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(WORD_W - 1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff <= dividend;
         div_ff <= divisor;
         rem_ff <= '0;
      end else if (busy_ff) begin
         dvd_ff <= {dvd_ff[WORD_W-2:0], 1'b0};
         if (trial >= div_ff) begin
            rem_ff <= diff[BOUND_W-1:0];
         end else begin
            rem_ff <= trial[BOUND_W-1:0];
         end
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

// ===== tb/sv/tb_counter_based_random_draw.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_counter_based_random_draw
// Self-checking bench for the counter-based random draw unit.
// ----------------------------------------------------------------------------
// Requests are queued by the stimulus process and sent by a clocked driver.
// Each accepted request beat is run through a local splitmix64 predictor that
// keeps its own seed and draw count. Every response beat is compared field by
// field with the oldest prediction. The run goes through six seeds, written
// only while the unit is drained. It starts with directed corner draws and
// then sends random draws, with bursty gaps and stalls on both channels for every seed but the last.
// ----------------------------------------------------------------------------
module tb_counter_based_random_draw;
   import cbrd_pkg::*;

   localparam longint BOUND_MIN = -64'sd2147483648;
   localparam longint BOUND_MAX = 64'sd2147483647;
   localparam int     NUM_SEEDS = 6;

   typedef struct {
      cmd_type            command;
      logic signed [31:0] range_low;
      logic signed [31:0] range_high;
      logic [PROB_W-1:0]  probability;
   } draw_request_type;

   typedef struct {
      logic [WORD_W-1:0]  raw_value;
      logic signed [31:0] int_value;
      logic [FRAC_W-1:0]  unit_fraction;
      logic               bool_value;
      logic [WORD_W-1:0]  draw_number;
      logic               range_error;
   } draw_result_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic [WORD_W-1:0] csr_wr_data;

   cbrd_req_if req_chan ();
   cbrd_rsp_if rsp_chan ();

   draw_request_type pending_draws[$];
   draw_result_type  expected_draws[$];

   logic [WORD_W-1:0] seed_shadow = '0;
   logic [WORD_W-1:0] draw_count_shadow = '0;

   bit idling = 1'b1;
   int send_gap = 0;
   int stall_left = 0;
   int draws_queued = 0;
   int draws_checked = 0;
   int failures = 0;
   int cmd_count[4] = '{0, 0, 0, 0};
   int range_errors_seen = 0;
   int bools_true = 0;

   counter_based_random_draw i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic draw_result_type predict_draw(draw_request_type rq,
                                                    logic [WORD_W-1:0] seed_v,
                                                    logic [WORD_W-1:0] number);
      draw_result_type   r;
      logic [WORD_W-1:0] z;
      logic [WORD_W-1:0] span;
      logic [PROB_W-1:0] p;
      longint            lo;
      longint            hi;
      z = seed_v + number * GOLDEN_STEP;
      z = (z ^ (z >> SHIFT_A)) * MIX_MUL_A;
      z = (z ^ (z >> SHIFT_B)) * MIX_MUL_B;
      z = z ^ (z >> SHIFT_C);
      r.raw_value     = z;
      r.unit_fraction = FRAC_W'(z >> (WORD_W - FRAC_W));
      r.draw_number   = number;
      r.int_value     = '0;
      r.bool_value    = 1'b0;
      r.range_error   = 1'b0;
      lo = rq.range_low;
      hi = rq.range_high;
      if (rq.command == CMD_INT) begin
         if (lo > hi) begin
            r.range_error = 1'b1;
         end else begin
            span = 64'(hi - lo) + 64'd1;
            r.int_value = rq.range_low + 32'(z % span);
         end
      end else if (rq.command == CMD_BOOL) begin
         p = rq.probability;
         if (p > PROB_ONE) begin
            p = PROB_ONE;
         end
         r.bool_value = (PROB_W'(r.unit_fraction) < p);
      end
      return r;
   endfunction

   function automatic longint random_bound();
      case ($urandom_range(0, 5))
         0: return BOUND_MIN;
         1: return BOUND_MAX;
         2: return longint'($urandom_range(0, 40)) - 20;
         default: return longint'(signed'($urandom));
      endcase
   endfunction

   task automatic add_request(cmd_type c, longint lo, longint hi, logic [PROB_W-1:0] p);
      draw_request_type rq;
      rq.command     = c;
      rq.range_low   = lo[31:0];
      rq.range_high  = hi[31:0];
      rq.probability = p;
      pending_draws.push_back(rq);
      draws_queued++;
   endtask

   task automatic add_random_request();
      longint      lo;
      longint      hi;
      longint      t;
      logic [63:0] r;
      logic [PROB_W-1:0] p;
      lo = random_bound();
      hi = random_bound();
      case ($urandom_range(0, 9))
         0: ;
         1, 2, 3, 4: begin
            hi = lo + longint'($urandom_range(0, 255));
            if (hi > BOUND_MAX) begin
               hi = BOUND_MAX;
            end
         end
         default: begin
            if (lo > hi) begin
               t = lo;
               lo = hi;
               hi = t;
            end
         end
      endcase
      r = {$urandom, $urandom};
      case ($urandom_range(0, 7))
         0: p = r[PROB_W-1:0];
         1: p = PROB_ONE;
         2: p = '0;
         default: p = PROB_W'(r % (64'(PROB_ONE) + 64'd1));
      endcase
      add_request(cmd_type'($urandom_range(0, 3)), lo, hi, p);
   endtask

   task automatic wait_drained();
      while (draws_checked != draws_queued) begin
         @(posedge clock);
      end
   endtask

   task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         $display("%0t: draw %0d %s mismatch, expected %h, actual %h",
                  $time, draws_checked + 1, name, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         send_gap = 0;
      end else if (!req_chan.valid || req_chan.ready) begin
         if (send_gap > 0) begin
            send_gap = send_gap - 1;
            req_chan.valid <= 1'b0;
         end else if (idling && $urandom_range(0, 3) == 0) begin
            send_gap = $urandom_range(1, 9) - 1;
            req_chan.valid <= 1'b0;
         end else if (pending_draws.size() > 0) begin
            draw_request_type rq;
            rq = pending_draws.pop_front();
            req_chan.valid       <= 1'b1;
            req_chan.command     <= rq.command;
            req_chan.range_low   <= rq.range_low;
            req_chan.range_high  <= rq.range_high;
            req_chan.probability <= rq.probability;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         draw_count_shadow = '0;
      end else if (req_chan.valid && req_chan.ready) begin
         draw_request_type rq;
         draw_result_type  res;
         rq.command     = cmd_type'(req_chan.command);
         rq.range_low   = req_chan.range_low;
         rq.range_high  = req_chan.range_high;
         rq.probability = req_chan.probability;
         draw_count_shadow = draw_count_shadow + 64'd1;
         res = predict_draw(rq, seed_shadow, draw_count_shadow);
         expected_draws.push_back(res);
         cmd_count[rq.command]++;
         if (res.range_error) begin
            range_errors_seen++;
         end
         if (res.bool_value) begin
            bools_true++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_chan.ready <= 1'b0;
      end else if (idling && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(1, 9) - 1;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_draws.size() == 0) begin
            $display("%0t: response beat with no draw outstanding, raw %h, draw number %h",
                     $time, rsp_chan.raw_value, rsp_chan.draw_number);
            failures++;
         end else begin
            draw_result_type want;
            want = expected_draws.pop_front();
            check_field("raw_value", want.raw_value, rsp_chan.raw_value);
            check_field("int_value", want.int_value, rsp_chan.int_value);
            check_field("unit_fraction", want.unit_fraction, rsp_chan.unit_fraction);
            check_field("bool_value", want.bool_value, rsp_chan.bool_value);
            check_field("draw_number", want.draw_number, rsp_chan.draw_number);
            check_field("range_error", want.range_error, rsp_chan.range_error);
            draws_checked++;
         end
      end
   end

   initial begin
      logic [WORD_W-1:0] seeds[NUM_SEEDS];
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      req_chan.valid = 1'b0;
      req_chan.command = CMD_RAW;
      req_chan.range_low = '0;
      req_chan.range_high = '0;
      req_chan.probability = '0;
      rsp_chan.ready = 1'b0;
      seeds[0] = 64'h0;
      seeds[1] = 64'hFFFF_FFFF_FFFF_FFFF;
      seeds[2] = {$urandom, $urandom};
      seeds[3] = 64'h1;
      seeds[4] = 64'h8000_0000_0000_0000;
      seeds[5] = {$urandom, $urandom};
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      for (int phase = 0; phase < NUM_SEEDS; phase++) begin
         wait_drained();
         csr_wr_en <= 1'b1;
         csr_wr_data <= seeds[phase];
         @(posedge clock);
         csr_wr_en <= 1'b0;
         seed_shadow = seeds[phase];
         idling = (phase != NUM_SEEDS - 1);
         if (phase == 0) begin
            add_request(CMD_RAW, 0, 0, '0);
            add_request(CMD_FRAC, BOUND_MAX, BOUND_MIN, '1);
            add_request(CMD_RAW, -1, -1, '1);
            add_request(CMD_INT, 0, 0, '0);
            add_request(CMD_INT, BOUND_MIN, BOUND_MAX, '0);
            add_request(CMD_INT, BOUND_MAX, BOUND_MAX, '0);
            add_request(CMD_INT, BOUND_MIN, BOUND_MIN, '0);
            add_request(CMD_INT, -1, 0, '0);
            add_request(CMD_INT, -5, 5, '1);
            add_request(CMD_INT, BOUND_MIN, -1, '0);
            add_request(CMD_INT, 0, BOUND_MAX, '0);
            add_request(CMD_INT, 1, 0, '0);
            add_request(CMD_INT, BOUND_MAX, BOUND_MIN, '0);
            add_request(CMD_INT, 0, -1, '0);
            add_request(CMD_BOOL, 0, 0, '0);
            add_request(CMD_BOOL, 0, 0, 54'd1);
            add_request(CMD_BOOL, 0, 0, PROB_ONE - 54'd1);
            add_request(CMD_BOOL, 0, 0, PROB_ONE);
            add_request(CMD_BOOL, 0, 0, PROB_ONE + 54'd1);
            add_request(CMD_BOOL, BOUND_MAX, BOUND_MIN, '1);
            add_request(CMD_BOOL, 0, 0, PROB_ONE >> 1);
         end
         repeat (phase == 0 ? 250 : 290) add_random_request();
      end
      wait_drained();
      repeat (100) @(posedge clock);
      $display("Checked %0d draws over %0d seeds: %0d raw, %0d integer, %0d fraction, %0d boolean.",
               draws_checked, NUM_SEEDS, cmd_count[CMD_RAW], cmd_count[CMD_INT],
               cmd_count[CMD_FRAC], cmd_count[CMD_BOOL]);
      $display("Inverted integer ranges flagged: %0d; boolean draws that came out true: %0d.",
               range_errors_seen, bools_true);
      if (failures == 0 && expected_draws.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("Timeout with %0d of %0d draws checked", draws_checked, draws_queued);
      $display("Test completed with failures");
      $finish;
   end

endmodule

// ===== sim.f =====
sv/cbrd_pkg.sv
sv/cbrd_req_if.sv
sv/cbrd_rsp_if.sv
sv/cbrd_mul.sv
sv/cbrd_mod.sv
sv/counter_based_random_draw.sv
tb/sv/tb_counter_based_random_draw.sv
